// ===== hdl/lbp3d_pkg.sv =====
// Shared constants, types and arithmetic helpers for the 3D-LBP window stream.
package lbp3d_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int PIX_W       = 8;
    localparam int WIN_N       = 9;
    localparam int RING_N      = 8;
    localparam int WIN_IDX_W   = 4;
    localparam int MAG_W       = 3;
    localparam int SUM_W       = 18;
    localparam int PROD_W      = 37;
    localparam int RECIP_SHIFT = 28;

    localparam logic [DIM_W-1:0]  DIM_MIN     = DIM_W'(3);
    localparam logic [DIM_W-1:0]  WIDTH_MAX   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]  HEIGHT_MAX  = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0]  WIDTH_RST   = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RST  = DIM_W'(480);
    localparam logic [SUM_W-1:0]  WEIGHT0     = SUM_W'(299);
    localparam logic [SUM_W-1:0]  WEIGHT1     = SUM_W'(587);
    localparam logic [SUM_W-1:0]  WEIGHT2     = SUM_W'(114);
    // ceil(2^28 / 1000): exact floor division by 1000 for sums below 2^18
    localparam logic [PROD_W-1:0] RECIP_1000  = PROD_W'(268436);
    localparam logic [PIX_W-1:0]  MAG_SAT     = PIX_W'(7);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [WIN_N-1:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } pos_t;

    localparam logic [WIN_IDX_W-1:0] RING [RING_N] = '{
        WIN_IDX_W'(0), WIN_IDX_W'(1), WIN_IDX_W'(2), WIN_IDX_W'(5),
        WIN_IDX_W'(8), WIN_IDX_W'(7), WIN_IDX_W'(6), WIN_IDX_W'(3)
    };

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] maxv
    );
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN)
            r = DIM_MIN;
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] weighted_sum(
        input logic [PIX_W-1:0] c0,
        input logic [PIX_W-1:0] c1,
        input logic [PIX_W-1:0] c2
    );
        return SUM_W'(c0) * WEIGHT0 + SUM_W'(c1) * WEIGHT1 + SUM_W'(c2) * WEIGHT2;
    endfunction

    function automatic logic [PIX_W-1:0] gray_of_sum(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * RECIP_1000;
        return p[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
    endfunction

endpackage

// ===== hdl/three_d_lbp_window_stream.sv =====
// Top level: streaming 3x3 3D-LBP over raster-order color pixels.
// One pixel is accepted per clock when the output side keeps up. An accepted pixel passes
// four registers in order (input register, weighted sum and line-store read, gray divide
// and window shift, code register). Both line stores share one 1024 x 16 memory with
// one read and one write port per cycle, which sets the one-pixel-per-clock rate.
// Pixels whose window center lies on the frame border produce no result. A write to
// the width or height register restarts the frame at row 0, column 0; no memory
// clearing is needed after reset.
module three_d_lbp_window_stream
    import lbp3d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      chan0,
    input  logic [PIX_W-1:0]      chan1,
    input  logic [PIX_W-1:0]      chan2,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      sign_code,
    output logic [PIX_W-1:0]      mag_plane_hi,
    output logic [PIX_W-1:0]      mag_plane_mid,
    output logic [PIX_W-1:0]      mag_plane_lo,
    output logic [ROW_W-1:0]      center_row,
    output logic [COL_W-1:0]      center_col
);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_c0_reg, s1_c1_reg, s1_c2_reg;
    pos_t             s1_pos_reg;

    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    pos_t             s2_pos_reg;

    logic             s3_valid_reg;
    pos_t             s3_center_reg;
    window_t          window_reg;

    logic                 accept, s1_adv, s2_adv;
    logic                 s1_ready, s2_ready, s3_ready, code_ready;
    logic                 s2_emit;
    logic [PIX_W-1:0]     gray;
    logic [2*PIX_W-1:0]   ram_rd;
    pos_t                 s2_center;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (DIM_W'(col_reg) + DIM_W'(1) == width_reg)
        begin
            col_next = '0;
            if (DIM_W'(row_reg) + DIM_W'(1) == height_reg)
                row_next = '0;
            else
                row_next = row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:
                begin
                    width_reg <= clamp_dim(cfg_data, WIDTH_MAX);
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                REG_HEIGHT:
                begin
                    height_reg <= clamp_dim(cfg_data, HEIGHT_MAX);
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // pipeline handshake
    assign s3_ready = !s3_valid_reg || code_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s2_adv   = s2_valid_reg && s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
                s3_valid_reg <= s2_emit;
            else if (code_ready)
                s3_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_c0_reg      <= chan0;
            s1_c1_reg      <= chan1;
            s1_c2_reg      <= chan2;
            s1_pos_reg.row <= row_reg;
            s1_pos_reg.col <= col_reg;
        end
        if (s1_adv)
        begin
            s2_sum_reg <= weighted_sum(s1_c0_reg, s1_c1_reg, s1_c2_reg);
            s2_pos_reg <= s1_pos_reg;
        end
        if (s2_adv)
        begin
            s3_center_reg <= s2_center;
        end
    end

    assign gray          = gray_of_sum(s2_sum_reg);
    assign s2_emit       = (s2_pos_reg.row >= ROW_W'(2)) && (s2_pos_reg.col >= COL_W'(2));
    assign s2_center.row = s2_pos_reg.row - ROW_W'(1);
    assign s2_center.col = s2_pos_reg.col - COL_W'(1);

    // shift the window left; new column is {two rows up, one row up, current}
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (s2_adv)
        begin
            window_reg[0] <= window_reg[1];
            window_reg[1] <= window_reg[2];
            window_reg[2] <= ram_rd[2*PIX_W-1:PIX_W];
            window_reg[3] <= window_reg[4];
            window_reg[4] <= window_reg[5];
            window_reg[5] <= ram_rd[PIX_W-1:0];
            window_reg[6] <= window_reg[7];
            window_reg[7] <= window_reg[8];
            window_reg[8] <= gray;
        end
    end

    lbp3d_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2*PIX_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s2_adv),
        .wr_addr (s2_pos_reg.col),
        .wr_data ({ram_rd[PIX_W-1:0], gray}),
        .rd_en   (s1_adv),
        .rd_addr (s1_pos_reg.col),
        .rd_data (ram_rd)
    );

    lbp3d_code_unit u_code_unit (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_valid     (s3_valid_reg),
        .win_ready     (code_ready),
        .win           (window_reg),
        .center        (s3_center_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sign_code     (sign_code),
        .mag_plane_hi  (mag_plane_hi),
        .mag_plane_mid (mag_plane_mid),
        .mag_plane_lo  (mag_plane_lo),
        .center_row    (center_row),
        .center_col    (center_col)
    );

endmodule

// ===== hdl/lbp3d_line_ram.sv =====
// Simple dual-port RAM with registered read, used for the two gray line stores.
module lbp3d_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lbp3d_code_unit.sv =====
// Sign and magnitude-plane code generation for one 3x3 window, with output register.
module lbp3d_code_unit
    import lbp3d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             win_valid,
    output logic             win_ready,
    input  window_t          win,
    input  pos_t             center,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] sign_code,
    output logic [PIX_W-1:0] mag_plane_hi,
    output logic [PIX_W-1:0] mag_plane_mid,
    output logic [PIX_W-1:0] mag_plane_lo,
    output logic [ROW_W-1:0] center_row,
    output logic [COL_W-1:0] center_col
);

    logic             out_valid_reg;
    logic [PIX_W-1:0] sign_reg, hi_reg, mid_reg, lo_reg;
    pos_t             center_reg;
    logic [PIX_W-1:0] sign_next, hi_next, mid_next, lo_next;
    logic             load;

    always_comb
    begin
        logic [PIX_W-1:0] nb;
        logic [PIX_W-1:0] cv;
        logic [PIX_W-1:0] diff;
        logic [MAG_W-1:0] mag;
        cv = win[4];
        sign_next = '0;
        hi_next   = '0;
        mid_next  = '0;
        lo_next   = '0;
        for (int k = 0; k < RING_N; k++)
        begin
            nb   = win[RING[k]];
            diff = (nb > cv) ? nb - cv : cv - nb;
            mag  = (diff > MAG_SAT) ? MAG_SAT[MAG_W-1:0] : diff[MAG_W-1:0];
            sign_next[RING_N-1-k] = (nb > cv);
            hi_next[RING_N-1-k]   = mag[2];
            mid_next[RING_N-1-k]  = mag[1];
            lo_next[RING_N-1-k]   = mag[0];
        end
    end

    assign win_ready = !out_valid_reg || out_ready;
    assign load      = win_valid && win_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sign_reg   <= sign_next;
            hi_reg     <= hi_next;
            mid_reg    <= mid_next;
            lo_reg     <= lo_next;
            center_reg <= center;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sign_code     = sign_reg;
    assign mag_plane_hi  = hi_reg;
    assign mag_plane_mid = mid_reg;
    assign mag_plane_lo  = lo_reg;
    assign center_row    = center_reg.row;
    assign center_col    = center_reg.col;

endmodule

// ===== tb/sv/lbp_window_checker.sv =====
// Checker for the 3D-LBP window stream: predicts codes from observed pixel beats and compares.
`timescale 1ns / 1ps
module lbp_window_checker
    import lbp3d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [PIX_W-1:0]      chan0,
    input  logic [PIX_W-1:0]      chan1,
    input  logic [PIX_W-1:0]      chan2,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [PIX_W-1:0]      sign_code,
    input  logic [PIX_W-1:0]      mag_plane_hi,
    input  logic [PIX_W-1:0]      mag_plane_mid,
    input  logic [PIX_W-1:0]      mag_plane_lo,
    input  logic [ROW_W-1:0]      center_row,
    input  logic [COL_W-1:0]      center_col,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [PIX_W-1:0] sign_bits;
        logic [PIX_W-1:0] mag_hi;
        logic [PIX_W-1:0] mag_mid;
        logic [PIX_W-1:0] mag_lo;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } lbp_codes_t;

    localparam int unsigned DIM_FLOOR = 3;
    localparam int unsigned MAG_CEIL  = 7;
    localparam logic [RING_N-1:0][3:0] CLOCKWISE =
        {4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd2, 4'd1, 4'd0};

    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [PIX_W-1:0] older_row [MAX_WIDTH];
    logic [PIX_W-1:0] newer_row [MAX_WIDTH];
    logic [PIX_W-1:0] window [WIN_N];
    int unsigned      next_col;
    int unsigned      next_row;
    lbp_codes_t       pending_codes [$];
    lbp_codes_t       want;
    int               fail_total;

    function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v,
                                            input int unsigned ceiling);
        if (v < DIM_FLOOR)
            return DIM_FLOOR;
        if (v > ceiling)
            return ceiling;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] luma(input logic [PIX_W-1:0] c0,
                                              input logic [PIX_W-1:0] c1,
                                              input logic [PIX_W-1:0] c2);
        int unsigned acc;
        acc = 299 * int'(c0) + 587 * int'(c1) + 114 * int'(c2);
        return PIX_W'(acc / 1000);
    endfunction

    task automatic reset_model();
        frame_width  = WIDTH_RST;
        frame_height = HEIGHT_RST;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (int i = 0; i < WIN_N; i++)
            window[i] = '0;
        next_col = 0;
        next_row = 0;
        pending_codes.delete();
        fail_total = 0;
    endtask

    task automatic shift_in_pixel(input logic [PIX_W-1:0] c0,
                                  input logic [PIX_W-1:0] c1,
                                  input logic [PIX_W-1:0] c2);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int unsigned      center;
        int unsigned      nb;
        int unsigned      diff;
        logic [PIX_W-1:0] gray;
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        logic [MAG_W-1:0] sat;
        lbp_codes_t       codes;
        w = fit_dim(frame_width, MAX_WIDTH);
        h = fit_dim(frame_height, MAX_HEIGHT);
        c = (next_col >= w) ? 0 : next_col;
        r = (next_row >= h) ? 0 : next_row;
        gray   = luma(c0, c1, c2);
        above2 = older_row[c];
        above1 = newer_row[c];
        for (int k = 0; k < 3; k++)
        begin
            window[k * 3]     = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2]    = above2;
        window[5]    = above1;
        window[8]    = gray;
        older_row[c] = above1;
        newer_row[c] = gray;
        if (r >= 2 && c >= 2)
        begin
            center = window[4];
            codes  = '0;
            for (int k = 0; k < RING_N; k++)
            begin
                nb   = window[CLOCKWISE[k]];
                diff = (nb > center) ? nb - center : center - nb;
                sat  = (diff > MAG_CEIL) ? MAG_W'(MAG_CEIL) : MAG_W'(diff);
                codes.sign_bits = {codes.sign_bits[PIX_W-2:0], nb > center};
                codes.mag_hi    = {codes.mag_hi[PIX_W-2:0], sat[2]};
                codes.mag_mid   = {codes.mag_mid[PIX_W-2:0], sat[1]};
                codes.mag_lo    = {codes.mag_lo[PIX_W-2:0], sat[0]};
            end
            codes.row = ROW_W'(r - 1);
            codes.col = COL_W'(c - 1);
            pending_codes.push_back(codes);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        next_col = c;
        next_row = r;
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_codes.size() == 0)
                begin
                    $error("result beat with nothing expected: row %0d col %0d",
                           center_row, center_col);
                    fail_total++;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    check_field("sign_code", want.sign_bits, sign_code);
                    check_field("mag_plane_hi", want.mag_hi, mag_plane_hi);
                    check_field("mag_plane_mid", want.mag_mid, mag_plane_mid);
                    check_field("mag_plane_lo", want.mag_lo, mag_plane_lo);
                    check_field("center_row", want.row, center_row);
                    check_field("center_col", want.col, center_col);
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_WIDTH:
                    begin
                        frame_width = cfg_data;
                        next_col    = 0;
                        next_row    = 0;
                    end
                    REG_HEIGHT:
                    begin
                        frame_height = cfg_data;
                        next_col     = 0;
                        next_row     = 0;
                    end
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                shift_in_pixel(chan0, chan1, chan2);
        end
        mismatches  <= fail_total;
        outstanding <= pending_codes.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the 3D-LBP window stream test: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module testbench;
    import lbp3d_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [DIM_W-1:0]     DIM_OVER    = 11'd2047;
    localparam int ITEM_TARGET  = 1250;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 45;
    localparam int WIDE_BEATS   = 40;
    localparam int NARROW_BEATS = 120;
    localparam int STALL_LIMIT  = 4000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [PIX_W-1:0]      chan0     = '0;
    logic [PIX_W-1:0]      chan1     = '0;
    logic [PIX_W-1:0]      chan2     = '0;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [PIX_W-1:0]      sign_code;
    logic [PIX_W-1:0]      mag_plane_hi;
    logic [PIX_W-1:0]      mag_plane_mid;
    logic [PIX_W-1:0]      mag_plane_lo;
    logic [ROW_W-1:0]      center_row;
    logic [COL_W-1:0]      center_col;

    int   mismatches;
    int   outstanding;
    int   send_idle_pct = 26;
    int   recv_idle_pct = 81;
    int   hold_left     = 0;
    bit   hold_done     = 1'b0;
    logic hold_arm      = 1'b0;
    int   idle_cycles   = 0;

    three_d_lbp_window_stream dut (.*);

    lbp_window_checker code_check (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge clk);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("three_d_lbp_window_stream test failed");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] c0, input logic [PIX_W-1:0] c1,
                              input logic [PIX_W-1:0] c2);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        chan0    <= c0;
        chan1    <= c1;
        chan2    <= c2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_pixel(input int base);
        int v;
        if ($urandom_range(0, 3) == 0)
            send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                       PIX_W'($urandom_range(0, 255)));
        else
        begin
            v = base + int'($urandom_range(0, 16)) - 8;
            if (v < 0)
                v = 0;
            else if (v > 255)
                v = 255;
            send_pixel(PIX_W'(v), PIX_W'(v), PIX_W'(v));
        end
    endtask

    // hold the enable high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int random_beats;
        int cur_width;
        int hgt;
        int w_eff;
        int n;
        int base;
        int pick;
        bit edge_dims_done;
        random_beats   = 0;
        cur_width      = 3;
        edge_dims_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_WIDTH, 11'd3);
        write_reg(REG_HEIGHT, 11'd3);
        cfg_wr_en <= 1'b0;
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd101, 8'd101, 8'd101);
        send_pixel(8'd96, 8'd96, 8'd96);
        send_pixel(8'd100, 8'd100, 8'd100);
        send_pixel(8'd107, 8'd107, 8'd107);
        send_pixel(8'd93, 8'd93, 8'd93);
        send_pixel(8'd100, 8'd100, 8'd100);
        send_pixel(8'd108, 8'd108, 8'd108);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hff, 8'h00);
        send_pixel(8'hff, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'h00);
        send_pixel(8'h00, 8'hff, 8'hff);
        wait_idle();

        write_reg(REG_WIDTH, 11'd0);
        write_reg(REG_HEIGHT, 11'd1);
        cfg_wr_en <= 1'b0;
        repeat (4) send_random_pixel(128);
        wait_idle();
        write_reg(REG_SPARE_B, 11'd5);
        write_reg(REG_SPARE_A, DIM_OVER);
        cfg_wr_en <= 1'b0;
        repeat (5) send_random_pixel(128);
        wait_idle();

        while (random_beats < ITEM_TARGET)
        begin
            if (random_beats < ITEM_TARGET / 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct <= 81;
            end
            else if (random_beats < 2 * ITEM_TARGET / 3)
            begin
                send_idle_pct = 81;
                recv_idle_pct <= 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                if (!edge_dims_done)
                begin
                    edge_dims_done = 1'b1;
                    write_reg(REG_WIDTH, DIM_OVER);
                    write_reg(REG_HEIGHT, 11'd3);
                    cfg_wr_en <= 1'b0;
                    base = $urandom_range(0, 255);
                    repeat (WIDE_BEATS) send_random_pixel(base);
                    wait_idle();
                    write_reg(REG_WIDTH, 11'd3);
                    write_reg(REG_HEIGHT, DIM_OVER);
                    cfg_wr_en <= 1'b0;
                    for (int i = 0; i < NARROW_BEATS; i++)
                    begin
                        if (i == HOLD_AT)
                            hold_arm <= 1'b1;
                        send_random_pixel(base);
                    end
                    wait_idle();
                    cur_width = 3;
                end
            end

            pick = $urandom_range(0, 3);
            if (pick != 2)
            begin
                if ($urandom_range(0, 7) == 0)
                    cur_width = $urandom_range(0, 2);
                else
                    cur_width = $urandom_range(3, 20);
                write_reg(REG_WIDTH, DIM_W'(cur_width));
            end
            if (pick != 1)
            begin
                case ($urandom_range(0, 7))
                    0:       hgt = $urandom_range(0, 2);
                    1:       hgt = $urandom_range(1025, 2047);
                    default: hgt = $urandom_range(3, 10);
                endcase
                write_reg(REG_HEIGHT, DIM_W'(hgt));
            end
            if (pick == 3)
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                          DIM_W'($urandom_range(0, 2047)));
            cfg_wr_en <= 1'b0;

            w_eff = (cur_width < 3) ? 3 : cur_width;
            n     = $urandom_range(w_eff, 16 * w_eff);
            base  = $urandom_range(0, 255);
            repeat (n)
            begin
                send_random_pixel(base);
                random_beats++;
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("three_d_lbp_window_stream test passed");
        else
            $display("three_d_lbp_window_stream test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lbp3d_pkg.sv
hdl/lbp3d_line_ram.sv
hdl/lbp3d_code_unit.sv
hdl/three_d_lbp_window_stream.sv
tb/sv/lbp_window_checker.sv
tb/sv/testbench.sv
